// ===== src/lzd_pkg.sv =====
`timescale 1ns / 1ps

package lzd_pkg;

	// History window and copy run sizing.
	localparam int HIST_AW = 12;
	localparam int MAX_RUN = 64;
	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam int CREM_W = 17;
	localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_RUN);

	// Stream type bytes and length biases.
	localparam logic [7:0] TYPE_LZ10 = 8'h10;
	localparam logic [7:0] TYPE_LZ11 = 8'h11;
	localparam logic [CREM_W-1:0] BIAS_LZ11_MID = 17'h00011;
	localparam logic [CREM_W-1:0] BIAS_LZ11_LONG = 17'h00111;
	localparam logic [7:0] LOW_NIBBLE = 8'h0F;

	// Result status codes.
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_PEND = 3'd1;
	localparam logic [2:0] ST_TRUNC = 3'd2;
	localparam logic [2:0] ST_BADDIST = 3'd3;
	localparam logic [2:0] ST_ZERO = 3'd4;
	localparam logic [2:0] ST_BUSY = 3'd5;

	// Detected formats.
	localparam logic [1:0] FMT_NONE = 2'd0;
	localparam logic [1:0] FMT_LZ10 = 2'd1;
	localparam logic [1:0] FMT_LZ11 = 2'd2;

	// Input opcodes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_CONT = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] in_byte;
		logic       in_last;
	} req_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_end;
		logic [2:0] status;
		logic [1:0] format;
	} rsp_t;

	typedef enum logic [1:0] {
		NEXT_FINAL,
		NEXT_HDR,
		NEXT_COPY
	} next_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic decode;
		logic hdr_emit;
		logic copy_rd;
		logic copy_wr;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic  emit_ok;
		logic  out_free;
		next_t next;
		logic  hdr_last;
		logic  run_last;
	} stat_t;

endpackage

// ===== src/lzd_ctrl.sv =====
`timescale 1ns / 1ps

module lzd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lzd_pkg::stat_t stat,
	output lzd_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_HDR,
		S_CPRD,
		S_CPWR,
		S_FINAL
	} state_t;

	state_t state_q;
	logic   stall_q;

	// Sequencer state and the registered input stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECODE;
						stall_q <= 1'b1;
					end
				end
				S_DECODE: begin
					case (stat.next)
						lzd_pkg::NEXT_HDR:  state_q <= S_HDR;
						lzd_pkg::NEXT_COPY: state_q <= S_CPRD;
						default:            state_q <= S_FINAL;
					endcase
				end
				S_HDR: begin
					if (stat.emit_ok && stat.hdr_last) begin
						state_q <= S_FINAL;
					end
				end
				S_CPRD: state_q <= S_CPWR;
				S_CPWR: begin
					if (stat.emit_ok) begin
						state_q <= stat.run_last ? S_FINAL : S_CPRD;
					end
				end
				S_FINAL: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign req_stall = stall_q;

	// Datapath commands follow the state and the output stage's room.
	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && req_valid;
		cmd.decode = (state_q == S_DECODE);
		cmd.hdr_emit = (state_q == S_HDR) && stat.emit_ok;
		cmd.copy_rd = (state_q == S_CPRD);
		cmd.copy_wr = (state_q == S_CPWR) && stat.emit_ok;
		cmd.finish = (state_q == S_FINAL) && stat.out_free;
	end

endmodule

// ===== src/lzd_datapath.sv =====
`timescale 1ns / 1ps

module lzd_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  lzd_pkg::req_t  req,
	input  logic           rsp_stall,
	input  lzd_pkg::cmd_t  cmd,
	output lzd_pkg::stat_t stat,
	output logic           rsp_valid,
	output lzd_pkg::rsp_t  rsp
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_EXTSIZE,
		PH_PASS,
		PH_DATA,
		PH_COPY,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		ACT_KEEP,
		ACT_NEW,
		ACT_DRAIN,
		ACT_COPY,
		ACT_DATA
	} act_t;

	localparam int AW = lzd_pkg::HIST_AW;
	localparam int RW = lzd_pkg::RUN_W;
	localparam int CW = lzd_pkg::CREM_W;

	// Item and stream parse state.
	lzd_pkg::req_t   item_q;
	phase_t          phase_q;
	logic [31:0]     produced_q;
	logic [31:0]     target_q;
	logic [7:0]      hold_q [4];
	logic [3:0]      hc_q;
	logic [1:0]      fmt_q;
	logic [7:0]      flag_bits_q;
	logic [3:0]      flag_idx_q;
	logic [7:0]      tok_q [3];
	logic [1:0]      tc_q;
	logic [CW-1:0]   crem_q;
	logic [11:0]     cdist_q;
	logic            ended_q;
	logic [RW-1:0]   run_q;
	logic [1:0]      hdr_i_q;
	logic [2:0]      hdr_n_q;

	// What the finishing step of the current item does.
	logic            plan_finish_q;
	logic [2:0]      plan_status_q;
	act_t            plan_act_q;
	logic            plan_end_q;

	// History memory with a registered read port.
	logic [7:0]      mem [1 << AW];
	logic [7:0]      rd_q;

	// Output stage: one result held back for patching, one presented.
	logic            pend_v_q;
	lzd_pkg::rsp_t   pend_q;
	logic            out_v_q;
	lzd_pkg::rsp_t   out_q;

	logic [7:0]      b;
	logic            last;
	logic            is_byte;
	logic            type_ok;
	logic [31:0]     hdr_size;
	logic [31:0]     ext_size;
	logic [7:0]      tok0;
	logic [2:0]      need;
	logic            tok_done;
	logic [CW-1:0]   len;
	logic [11:0]     disp;
	logic            bad_dist;
	logic [31:0]     room;
	logic [CW-1:0]   cmin;
	logic            fbit;
	logic            lit_c;
	logic            pass_c;
	logic            emit_c;
	lzd_pkg::rsp_t   res_c;
	logic            hdr_last;
	logic            out_free;
	logic [AW-1:0]   src_addr;
	logic            mem_we;
	logic [7:0]      mem_wd;
	logic [2:0]      eff_status;
	logic            eff_end;
	act_t            eff_act;
	logic            fin_load;
	lzd_pkg::rsp_t   fin_res;
	lzd_pkg::rsp_t   st_res;
	lzd_pkg::next_t  next_c;

	function automatic logic [RW-1:0] min_run(input logic [CW-1:0] n);
		if (n < CW'(lzd_pkg::MAX_RUN)) begin
			return n[RW-1:0];
		end
		return lzd_pkg::RUN_MAX;
	endfunction

	assign b = item_q.in_byte;
	assign last = item_q.in_last;
	assign is_byte = (item_q.opcode == lzd_pkg::OP_BYTE);

	// Header fields.
	assign type_ok = (hold_q[0] == lzd_pkg::TYPE_LZ10) || (hold_q[0] == lzd_pkg::TYPE_LZ11);
	assign hdr_size = {8'd0, b, hold_q[2], hold_q[1]};

	always_comb begin
		case (hc_q[1:0])
			2'd0:    ext_size = target_q | {24'd0, b};
			2'd1:    ext_size = target_q | {16'd0, b, 8'd0};
			2'd2:    ext_size = target_q | {8'd0, b, 16'd0};
			default: ext_size = target_q | {b, 24'd0};
		endcase
	end

	// Token decode: byte count, length and distance of a back-reference.
	assign tok0 = (tc_q == 2'd0) ? b : tok_q[0];

	always_comb begin
		if (fmt_q == lzd_pkg::FMT_LZ11) begin
			if (tok0[7:4] == 4'd0) begin
				need = 3'd3;
			end else if (tok0[7:4] == 4'd1) begin
				need = 3'd4;
			end else begin
				need = 3'd2;
			end
		end else begin
			need = 3'd2;
		end
	end

	assign tok_done = ({1'b0, tc_q} + 3'd1) >= need;

	always_comb begin
		if (fmt_q != lzd_pkg::FMT_LZ11) begin
			len = CW'(tok_q[0][7:4]) + CW'(3);
			disp = {tok_q[0][3:0], b};
		end else if (need == 3'd3) begin
			len = CW'({tok_q[0][3:0], tok_q[1][7:4]}) + lzd_pkg::BIAS_LZ11_MID;
			disp = {tok_q[1][3:0], b};
		end else if (need == 3'd4) begin
			len = CW'({tok_q[0][3:0], tok_q[1], tok_q[2][7:4]}) + lzd_pkg::BIAS_LZ11_LONG;
			disp = {tok_q[2][3:0], b};
		end else begin
			len = CW'(tok_q[0][7:4]) + CW'(1);
			disp = {tok_q[0][3:0] & lzd_pkg::LOW_NIBBLE[3:0], b};
		end
	end

	// A distance reaches before the start of the output when disp + 1 > produced.
	assign bad_dist = ({20'd0, disp} >= produced_q);
	assign room = target_q - produced_q;
	assign cmin = (room < {15'd0, len}) ? room[CW-1:0] : len;

	assign fbit = flag_bits_q[3'(flag_idx_q - 4'd1)];
	assign lit_c = is_byte && (phase_q == PH_DATA) && (flag_idx_q != 4'd0) && !fbit;
	assign pass_c = is_byte && (phase_q == PH_PASS);

	// Where the sequencer goes after decode.
	always_comb begin
		next_c = lzd_pkg::NEXT_FINAL;
		if (!is_byte) begin
			if (phase_q == PH_COPY) begin
				next_c = lzd_pkg::NEXT_COPY;
			end
		end else if (phase_q == PH_HEADER) begin
			if ((hc_q < 4'd3 && last) || (hc_q == 4'd3 && !type_ok)) begin
				next_c = lzd_pkg::NEXT_HDR;
			end
		end else if (phase_q == PH_DATA && flag_idx_q != 4'd0 && fbit && tok_done && !bad_dist) begin
			next_c = lzd_pkg::NEXT_COPY;
		end
	end

	// New byte result.
	assign hdr_last = ({1'b0, hdr_i_q} + 3'd1) == hdr_n_q;
	assign emit_c = (cmd.decode && (lit_c || pass_c)) || cmd.hdr_emit || cmd.copy_wr;

	always_comb begin
		res_c = '0;
		res_c.has_byte = 1'b1;
		res_c.status = lzd_pkg::ST_OK;
		res_c.format = fmt_q;
		if (cmd.copy_wr) begin
			res_c.out_byte = rd_q;
		end else if (cmd.hdr_emit) begin
			res_c.out_byte = hold_q[hdr_i_q];
		end else begin
			res_c.out_byte = b;
		end
		res_c.stream_end = cmd.hdr_emit ? (plan_end_q && hdr_last) : (pass_c && last);
	end

	// Outcome of the item: a fixed plan, or the end-of-item output check.
	always_comb begin
		eff_status = plan_status_q;
		eff_end = 1'b0;
		eff_act = plan_act_q;
		if (plan_finish_q) begin
			eff_status = lzd_pkg::ST_OK;
			if (produced_q >= target_q) begin
				eff_end = 1'b1;
				eff_act = plan_end_q ? ACT_NEW : ACT_DRAIN;
			end else if (crem_q != '0) begin
				eff_status = lzd_pkg::ST_PEND;
				eff_act = ACT_COPY;
			end else if (plan_end_q) begin
				eff_status = lzd_pkg::ST_TRUNC;
				eff_act = ACT_NEW;
			end else begin
				eff_act = ACT_DATA;
			end
		end
	end

	always_comb begin
		fin_res = pend_q;
		fin_res.run_last = 1'b1;
		fin_res.status = eff_status;
		fin_res.stream_end = pend_q.stream_end | eff_end;
		st_res = '0;
		st_res.run_last = 1'b1;
		st_res.status = eff_status;
		st_res.format = fmt_q;
	end

	assign fin_load = cmd.finish && (pend_v_q || eff_status != lzd_pkg::ST_OK);

	// Parse state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			produced_q <= '0;
			target_q <= '0;
			hc_q <= '0;
			fmt_q <= lzd_pkg::FMT_NONE;
			flag_bits_q <= '0;
			flag_idx_q <= '0;
			tc_q <= '0;
			crem_q <= '0;
			cdist_q <= '0;
			ended_q <= 1'b0;
			run_q <= '0;
			hdr_i_q <= '0;
			hdr_n_q <= '0;
			plan_finish_q <= 1'b0;
			plan_status_q <= lzd_pkg::ST_OK;
			plan_act_q <= ACT_KEEP;
			plan_end_q <= 1'b0;
		end else if (cmd.decode) begin
			plan_finish_q <= 1'b0;
			plan_status_q <= lzd_pkg::ST_OK;
			plan_act_q <= ACT_KEEP;
			plan_end_q <= 1'b0;
			if (!is_byte) begin
				if (phase_q == PH_COPY) begin
					run_q <= min_run(crem_q);
					plan_finish_q <= 1'b1;
					plan_end_q <= ended_q;
				end
			end else begin
				case (phase_q)
					PH_COPY: plan_status_q <= lzd_pkg::ST_BUSY;
					PH_DRAIN: begin
						if (last) begin
							plan_act_q <= ACT_NEW;
						end
					end
					PH_PASS: begin
						if (last) begin
							plan_act_q <= ACT_NEW;
						end
					end
					PH_HEADER: begin
						if (hc_q < 4'd3) begin
							hc_q <= hc_q + 4'd1;
							if (last) begin
								hdr_i_q <= '0;
								hdr_n_q <= 3'(hc_q + 4'd1);
								plan_end_q <= 1'b1;
								plan_act_q <= ACT_NEW;
							end
						end else if (type_ok) begin
							fmt_q <= (hold_q[0] == lzd_pkg::TYPE_LZ10) ?
								lzd_pkg::FMT_LZ10 : lzd_pkg::FMT_LZ11;
							target_q <= hdr_size;
							hc_q <= 4'd4;
							if (hold_q[0] == lzd_pkg::TYPE_LZ11 && hdr_size == '0) begin
								if (last) begin
									plan_status_q <= lzd_pkg::ST_TRUNC;
									plan_act_q <= ACT_NEW;
								end else begin
									phase_q <= PH_EXTSIZE;
								end
							end else if (hdr_size == '0) begin
								plan_status_q <= lzd_pkg::ST_ZERO;
								plan_act_q <= last ? ACT_NEW : ACT_DRAIN;
							end else begin
								phase_q <= PH_DATA;
								flag_idx_q <= '0;
								tc_q <= '0;
								if (last) begin
									plan_status_q <= lzd_pkg::ST_TRUNC;
									plan_act_q <= ACT_NEW;
								end
							end
						end else begin
							hdr_i_q <= '0;
							hdr_n_q <= 3'd4;
							plan_end_q <= last;
							if (last) begin
								plan_act_q <= ACT_NEW;
							end else begin
								phase_q <= PH_PASS;
							end
						end
					end
					PH_EXTSIZE: begin
						target_q <= ext_size;
						hc_q <= hc_q + 4'd1;
						if (hc_q == 4'd7) begin
							if (ext_size == '0) begin
								plan_status_q <= lzd_pkg::ST_ZERO;
								plan_act_q <= last ? ACT_NEW : ACT_DRAIN;
							end else begin
								phase_q <= PH_DATA;
								flag_idx_q <= '0;
								tc_q <= '0;
								if (last) begin
									plan_status_q <= lzd_pkg::ST_TRUNC;
									plan_act_q <= ACT_NEW;
								end
							end
						end else if (last) begin
							plan_status_q <= lzd_pkg::ST_TRUNC;
							plan_act_q <= ACT_NEW;
						end
					end
					PH_DATA: begin
						if (flag_idx_q == 4'd0) begin
							flag_bits_q <= b;
							flag_idx_q <= 4'd8;
							plan_finish_q <= 1'b1;
							plan_end_q <= last;
						end else if (!fbit) begin
							flag_idx_q <= flag_idx_q - 4'd1;
							produced_q <= produced_q + 32'd1;
							plan_finish_q <= 1'b1;
							plan_end_q <= last;
						end else if (!tok_done) begin
							tc_q <= tc_q + 2'd1;
							plan_finish_q <= 1'b1;
							plan_end_q <= last;
						end else begin
							tc_q <= '0;
							flag_idx_q <= flag_idx_q - 4'd1;
							if (bad_dist) begin
								plan_status_q <= lzd_pkg::ST_BADDIST;
								plan_act_q <= last ? ACT_NEW : ACT_DRAIN;
							end else begin
								crem_q <= cmin;
								cdist_q <= disp;
								run_q <= min_run(cmin);
								plan_finish_q <= 1'b1;
								plan_end_q <= last;
							end
						end
					end
					default: plan_act_q <= ACT_NEW;
				endcase
			end
		end else if (cmd.hdr_emit) begin
			hdr_i_q <= hdr_i_q + 2'd1;
		end else if (cmd.copy_wr) begin
			produced_q <= produced_q + 32'd1;
			crem_q <= crem_q - CW'(1);
			run_q <= run_q - RW'(1);
		end else if (cmd.finish) begin
			case (eff_act)
				ACT_NEW: begin
					phase_q <= PH_HEADER;
					produced_q <= '0;
					target_q <= '0;
					hc_q <= '0;
					fmt_q <= lzd_pkg::FMT_NONE;
					flag_bits_q <= '0;
					flag_idx_q <= '0;
					tc_q <= '0;
					crem_q <= '0;
					cdist_q <= '0;
					ended_q <= 1'b0;
				end
				ACT_DRAIN: phase_q <= PH_DRAIN;
				ACT_COPY: begin
					phase_q <= PH_COPY;
					ended_q <= plan_end_q;
				end
				ACT_DATA: phase_q <= PH_DATA;
				default: ;
			endcase
		end
	end

	// Item, header and token byte holding.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.decode && is_byte && phase_q == PH_HEADER) begin
			hold_q[hc_q[1:0]] <= b;
		end
		if (cmd.decode && is_byte && phase_q == PH_DATA && flag_idx_q != 4'd0 && fbit
				&& !tok_done) begin
			tok_q[tc_q] <= b;
		end
	end

	// History memory: literals and copied bytes go in at the output position.
	assign src_addr = produced_q[AW-1:0] - cdist_q - AW'(1);
	assign mem_we = (cmd.decode && lit_c) || cmd.copy_wr;
	assign mem_wd = cmd.copy_wr ? rd_q : b;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[produced_q[AW-1:0]] <= mem_wd;
		end
		if (cmd.copy_rd) begin
			rd_q <= mem[src_addr];
		end
	end

	// Output stage control.
	assign out_free = !out_v_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit_c) begin
				pend_v_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_v_q <= 1'b0;
			end
			if ((emit_c && pend_v_q) || fin_load) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_c) begin
			pend_q <= res_c;
		end
		if (emit_c && pend_v_q) begin
			out_q <= pend_q;
		end else if (fin_load) begin
			out_q <= pend_v_q ? fin_res : st_res;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp = out_q;

	always_comb begin
		stat = '0;
		stat.emit_ok = !pend_v_q || out_free;
		stat.out_free = out_free;
		stat.next = next_c;
		stat.hdr_last = hdr_last;
		stat.run_last = (run_q == RW'(1)) || (run_q == '0);
	end

endmodule

// ===== src/lz10_lz11_stream_decompressor.sv =====
`timescale 1ns / 1ps

// LZ10/LZ11 stream decompressor. Compressed bytes enter one per transaction
// (opcode 0); the first byte selects LZ10 (0x10), LZ11 (0x11) or plain
// passthrough, followed by the little-endian size. Results leave one per
// transaction, and the last result of each input transaction carries
// run_last and the status code. An input transaction is accepted, decoded
// and closed out, with an emit step for each passed-through header byte and
// a read of the 4096-byte history RAM followed by its write for each copied
// byte; a copy emits at most 64 bytes per transaction and opcode 1 fetches
// the rest. The history RAM is not cleared after reset: a back-reference
// is only checked against the bytes produced in the current stream. While a
// result waits on the output, the block keeps decoding until its output
// stage fills.
module lz10_lz11_stream_decompressor (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lzd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lzd_pkg::rsp_t rsp
);

	lzd_pkg::cmd_t  cmd;
	lzd_pkg::stat_t stat;

	lzd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lzd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== src/lzd_checker.sv =====
`timescale 1ns / 1ps

module lzd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input lzd_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input lzd_pkg::rsp_t rsp
);

	// A presented result holds while the consumer stalls.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// An accepted transaction blocks further input until it is worked off.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input not stalled after a transaction");

	// A status-only result closes its transaction with a real code.
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_byte |-> rsp.run_last && rsp.out_byte == 8'd0
			&& rsp.status != lzd_pkg::ST_OK)
		else $error("malformed status-only result");

	// A status code rides only on the last result of a transaction.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != lzd_pkg::ST_OK |-> rsp.run_last)
		else $error("status on a non-final result");

	// Codes and formats stay within their defined sets.
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= lzd_pkg::ST_BUSY && rsp.format <= lzd_pkg::FMT_LZ11)
		else $error("undefined status or format code");

endmodule

bind lz10_lz11_stream_decompressor lzd_checker u_lzd_checker (.*);

// ===== sim/tb_lz10_lz11_stream_decompressor.sv =====
`timescale 1ns / 1ps

module tb_lz10_lz11_stream_decompressor;

	localparam int HIST_DEPTH = 4096;
	localparam int STALL_LIMIT = 20000;

	// Decoder phases of the predictor.
	typedef enum int {
		PH_HEADER,
		PH_EXTSIZE,
		PH_PASS,
		PH_DATA,
		PH_COPY,
		PH_DRAIN
	} phase_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	lzd_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	lzd_pkg::rsp_t rsp;

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int quiet_cycles;
	int sent_items;

	// Predictor state.
	logic [7:0] hist [HIST_DEPTH];
	logic [31:0] out_count;
	logic [31:0] size_goal;
	logic [7:0] hdr_bytes [3];
	int hdr_count;
	logic [1:0] fmt;
	phase_t phase;
	logic [7:0] flags;
	int flag_pos;
	logic [7:0] tok [3];
	int tok_count;
	logic [31:0] copy_left;
	logic [11:0] copy_dist;
	logic ended_flag;

	lzd_pkg::rsp_t item_rsps [$];
	lzd_pkg::rsp_t pending_rsps [$];
	lzd_pkg::req_t stim_q [$];

	lz10_lz11_stream_decompressor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void restart_stream();
		out_count = '0;
		size_goal = '0;
		hdr_count = 0;
		fmt = lzd_pkg::FMT_NONE;
		phase = PH_HEADER;
		flags = '0;
		flag_pos = 0;
		tok_count = 0;
		copy_left = '0;
		copy_dist = '0;
		ended_flag = 1'b0;
	endfunction

	function automatic void push_rsp(logic has, logic [7:0] b, logic fin, logic [2:0] st);
		lzd_pkg::rsp_t r;
		r.has_byte = has;
		r.out_byte = b;
		r.run_last = 1'b0;
		r.stream_end = fin;
		r.status = st;
		r.format = fmt;
		if (item_rsps.size() < lzd_pkg::MAX_RUN)
			item_rsps.push_back(r);
	endfunction

	function automatic void mark_status(logic [2:0] st);
		if (item_rsps.size() == 0) begin
			push_rsp(1'b0, 8'h00, 1'b0, st);
		end else begin
			item_rsps[item_rsps.size()-1].status = st;
		end
	endfunction

	function automatic void abort_stream(logic [2:0] st, logic ended);
		mark_status(st);
		if (ended) begin
			restart_stream();
		end else begin
			phase = PH_DRAIN;
		end
	endfunction

	function automatic void emit_byte(logic [7:0] b);
		hist[out_count % HIST_DEPTH] = b;
		out_count++;
		push_rsp(1'b1, b, 1'b0, lzd_pkg::ST_OK);
	endfunction

	function automatic void copy_run();
		int n;
		n = (copy_left < lzd_pkg::MAX_RUN) ? copy_left : lzd_pkg::MAX_RUN;
		for (int i = 0; i < n; i++) begin
			emit_byte(hist[(out_count - copy_dist - 1) % HIST_DEPTH]);
		end
		copy_left -= n;
	endfunction

	function automatic void settle(logic ended);
		if (out_count >= size_goal) begin
			if (item_rsps.size() > 0)
				item_rsps[item_rsps.size()-1].stream_end = 1'b1;
			if (ended) begin
				restart_stream();
			end else begin
				phase = PH_DRAIN;
			end
		end else if (copy_left > 0) begin
			mark_status(lzd_pkg::ST_PEND);
			ended_flag = ended;
			phase = PH_COPY;
		end else if (ended) begin
			abort_stream(lzd_pkg::ST_TRUNC, 1'b1);
		end else begin
			phase = PH_DATA;
		end
	endfunction

	function automatic void begin_data(logic ended);
		if (size_goal == 0) begin
			abort_stream(lzd_pkg::ST_ZERO, ended);
			return;
		end
		phase = PH_DATA;
		flag_pos = 0;
		tok_count = 0;
		if (ended)
			abort_stream(lzd_pkg::ST_TRUNC, 1'b1);
	endfunction

	function automatic int token_len_bytes(logic [7:0] first);
		if (fmt != lzd_pkg::FMT_LZ11)
			return 2;
		if (first[7:4] == 4'd0)
			return 3;
		if (first[7:4] == 4'd1)
			return 4;
		return 2;
	endfunction

	function automatic void decode_data(logic [7:0] b, logic ended);
		int need;
		logic [31:0] len;
		logic [31:0] disp;
		logic [31:0] room;
		if (flag_pos == 0) begin
			flags = b;
			flag_pos = 8;
			settle(ended);
			return;
		end
		if (flags[flag_pos-1] == 1'b0) begin
			flag_pos--;
			emit_byte(b);
			settle(ended);
			return;
		end
		need = token_len_bytes(tok_count == 0 ? b : tok[0]);
		if (tok_count + 1 < need) begin
			tok[tok_count] = b;
			tok_count++;
			settle(ended);
			return;
		end
		if (fmt != lzd_pkg::FMT_LZ11) begin
			len = tok[0][7:4] + 3;
			disp = {tok[0][3:0], b};
		end else if (need == 3) begin
			len = {tok[0][3:0], tok[1][7:4]} + lzd_pkg::BIAS_LZ11_MID;
			disp = {tok[1][3:0], b};
		end else if (need == 4) begin
			len = {tok[0][3:0], tok[1], tok[2][7:4]} + lzd_pkg::BIAS_LZ11_LONG;
			disp = {tok[2][3:0], b};
		end else begin
			len = tok[0][7:4] + 1;
			disp = {tok[0][3:0], b};
		end
		tok_count = 0;
		flag_pos--;
		if (disp + 1 > out_count) begin
			abort_stream(lzd_pkg::ST_BADDIST, ended);
			return;
		end
		room = size_goal - out_count;
		copy_left = (len < room) ? len : room;
		copy_dist = disp[11:0];
		copy_run();
		settle(ended);
	endfunction

	function automatic void decode_header(logic [7:0] b, logic ended);
		if (hdr_count < 3) begin
			hdr_bytes[hdr_count] = b;
			hdr_count++;
			if (ended) begin
				for (int i = 0; i < hdr_count; i++)
					push_rsp(1'b1, hdr_bytes[i], i + 1 == hdr_count, lzd_pkg::ST_OK);
				restart_stream();
			end
			return;
		end
		if (hdr_bytes[0] == lzd_pkg::TYPE_LZ10 || hdr_bytes[0] == lzd_pkg::TYPE_LZ11) begin
			fmt = (hdr_bytes[0] == lzd_pkg::TYPE_LZ10) ? lzd_pkg::FMT_LZ10 : lzd_pkg::FMT_LZ11;
			size_goal = {8'h00, b, hdr_bytes[2], hdr_bytes[1]};
			hdr_count = 4;
			if (fmt == lzd_pkg::FMT_LZ11 && size_goal == 0) begin
				if (ended) begin
					abort_stream(lzd_pkg::ST_TRUNC, 1'b1);
				end else begin
					phase = PH_EXTSIZE;
				end
			end else begin
				begin_data(ended);
			end
			return;
		end
		for (int i = 0; i < 3; i++)
			push_rsp(1'b1, hdr_bytes[i], 1'b0, lzd_pkg::ST_OK);
		push_rsp(1'b1, b, ended, lzd_pkg::ST_OK);
		if (ended) begin
			restart_stream();
		end else begin
			phase = PH_PASS;
		end
	endfunction

	// Work out the results of one accepted input transaction.
	function automatic void predict_decode(lzd_pkg::req_t r);
		item_rsps.delete();
		if (r.opcode == lzd_pkg::OP_CONT) begin
			if (phase == PH_COPY) begin
				copy_run();
				settle(ended_flag);
			end
		end else begin
			case (phase)
				PH_COPY: push_rsp(1'b0, 8'h00, 1'b0, lzd_pkg::ST_BUSY);
				PH_DRAIN: if (r.in_last) restart_stream();
				PH_PASS: begin
					push_rsp(1'b1, r.in_byte, r.in_last, lzd_pkg::ST_OK);
					if (r.in_last)
						restart_stream();
				end
				PH_HEADER: decode_header(r.in_byte, r.in_last);
				PH_EXTSIZE: begin
					size_goal |= 32'(r.in_byte) << ((hdr_count - 4) * 8);
					hdr_count++;
					if (hdr_count >= 8) begin
						begin_data(r.in_last);
					end else if (r.in_last) begin
						abort_stream(lzd_pkg::ST_TRUNC, 1'b1);
					end
				end
				default: decode_data(r.in_byte, r.in_last);
			endcase
		end
		if (item_rsps.size() > 0)
			item_rsps[item_rsps.size()-1].run_last = 1'b1;
		foreach (item_rsps[i])
			pending_rsps.push_back(item_rsps[i]);
	endfunction

	function automatic lzd_pkg::req_t mk(logic op, logic [7:0] b, logic fin);
		lzd_pkg::req_t r;
		r.opcode = op;
		r.in_byte = b;
		r.in_last = fin;
		return r;
	endfunction

	// A well-formed compressed stream, or a passthrough one, with random content; small sizes mostly.
	task automatic add_stream(logic [1:0] kind);
		int size;
		int made;
		int nflag;
		logic [7:0] fl;
		logic [7:0] tk0;
		int ln;
		int ds;
		size = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
		if (kind == lzd_pkg::FMT_NONE) begin
			for (int i = 0; i < size + 4; i++)
				stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'($urandom), i == size + 3));
			return;
		end
		stim_q.push_back(mk(lzd_pkg::OP_BYTE,
			kind == lzd_pkg::FMT_LZ10 ? lzd_pkg::TYPE_LZ10 : lzd_pkg::TYPE_LZ11, 1'b0));
		if (kind == lzd_pkg::FMT_LZ11 && $urandom_range(0, 3) == 0) begin
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'(size), 1'b0));
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'(size >> 8), 1'b0));
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		end else begin
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'(size), 1'b0));
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'(size >> 8), 1'b0));
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		end
		made = 0;
		while (made < size) begin
			fl = (made == 0) ? {1'b0, 7'($urandom)} : 8'($urandom);
			stim_q.push_back(mk(lzd_pkg::OP_BYTE, fl, 1'b0));
			for (int b = 7; b >= 0 && made < size; b--) begin
				if (!fl[b]) begin
					stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'($urandom), 1'b0));
					made++;
				end else begin
					ds = $urandom_range(0, (made < 4096 ? made : 4096) - 1);
					if (kind == lzd_pkg::FMT_LZ10) begin
						ln = $urandom_range(3, 18);
						stim_q.push_back(mk(lzd_pkg::OP_BYTE,
							{4'(ln - 3), 4'(ds >> 8)}, 1'b0));
					end else begin
						case ($urandom_range(0, 2))
							0: begin
								// The short form needs a first nibble of two or more.
								ln = $urandom_range(3, 16);
								stim_q.push_back(mk(lzd_pkg::OP_BYTE,
									{4'(ln - 1), 4'(ds >> 8)}, 1'b0));
							end
							1: begin
								ln = $urandom_range(17, 272);
								tk0 = 8'(ln - 17);
								stim_q.push_back(mk(lzd_pkg::OP_BYTE,
									{4'h0, tk0[7:4]}, 1'b0));
								stim_q.push_back(mk(lzd_pkg::OP_BYTE,
									{tk0[3:0], 4'(ds >> 8)}, 1'b0));
							end
							default: begin
								ln = $urandom_range(273, 400);
								stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'h10, 1'b0));
								stim_q.push_back(mk(lzd_pkg::OP_BYTE,
									8'((ln - 273) >> 4), 1'b0));
								stim_q.push_back(mk(lzd_pkg::OP_BYTE,
									{4'(ln - 273), 4'(ds >> 8)}, 1'b0));
							end
						endcase
					end
					stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'(ds), 1'b0));
					made += ln;
					for (int c = 64; c < ln; c += 64)
						stim_q.push_back(mk(lzd_pkg::OP_CONT, 8'($urandom), 1'b0));
				end
			end
		end
		stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'($urandom), 1'b1));
	endtask

	// Drive one transaction and hold it until it is accepted.
	task automatic send_item(lzd_pkg::req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_decode(r);
		sent_items++;
	endtask

	task automatic drain_wait();
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Receiver: random stall and checking of accepted results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsps.size() == 0) begin
					errors++;
					$error("unexpected result %p", rsp);
				end else begin
					lzd_pkg::rsp_t e;
					e = pending_rsps.pop_front();
					if (rsp.has_byte !== e.has_byte)
						$error("has_byte exp %0d got %0d", e.has_byte, rsp.has_byte);
					if (rsp.out_byte !== e.out_byte)
						$error("out_byte exp %0h got %0h", e.out_byte, rsp.out_byte);
					if (rsp.run_last !== e.run_last)
						$error("run_last exp %0d got %0d", e.run_last, rsp.run_last);
					if (rsp.stream_end !== e.stream_end)
						$error("stream_end exp %0d got %0d", e.stream_end, rsp.stream_end);
					if (rsp.status !== e.status)
						$error("status exp %0d got %0d", e.status, rsp.status);
					if (rsp.format !== e.format)
						$error("format exp %0d got %0d", e.format, rsp.format);
					if (rsp !== e)
						errors++;
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog on cycles with no accepted transaction.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_lz10_lz11_stream_decompressor failed");
				$finish;
			end
		end
	end

	// Directed rows: stimulus plus a typed-in expectation where obvious.
	typedef struct {
		lzd_pkg::req_t stim;
		logic          has_exp;
		lzd_pkg::rsp_t exp;
	} row_t;

	row_t rows [$];

	function automatic lzd_pkg::rsp_t rs(logic h, logic [7:0] b, logic rl, logic se,
		logic [2:0] st, logic [1:0] f);
		lzd_pkg::rsp_t r;
		r.has_byte = h;
		r.out_byte = b;
		r.run_last = rl;
		r.stream_end = se;
		r.status = st;
		r.format = f;
		return r;
	endfunction

	function automatic void row(lzd_pkg::req_t s);
		row_t x;
		x.stim = s;
		x.has_exp = 1'b0;
		rows.push_back(x);
	endfunction

	function automatic void row_exp(lzd_pkg::req_t s, lzd_pkg::rsp_t e);
		row_t x;
		x.stim = s;
		x.has_exp = 1'b1;
		x.exp = e;
		rows.push_back(x);
	endfunction

	initial begin
		int phase_sel;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		errors = 0;
		quiet_cycles = 0;
		sent_items = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (hist[i])
			hist[i] = 8'h00;
		restart_stream();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Continue with nothing pending; one-byte passthrough of the extreme.
		row(mk(lzd_pkg::OP_CONT, 8'hFF, 1'b0));
		row_exp(mk(lzd_pkg::OP_BYTE, 8'hFF, 1'b1),
			rs(1'b1, 8'hFF, 1'b1, 1'b1, lzd_pkg::ST_OK, lzd_pkg::FMT_NONE));
		// LZ10 zero size, then drained up to the last byte.
		row(mk(lzd_pkg::OP_BYTE, lzd_pkg::TYPE_LZ10, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row_exp(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0),
			rs(1'b0, 8'h00, 1'b1, 1'b0, lzd_pkg::ST_ZERO, lzd_pkg::FMT_LZ10));
		row(mk(lzd_pkg::OP_BYTE, 8'h55, 1'b1));
		// LZ10 of size 5 with a bad distance token.
		row(mk(lzd_pkg::OP_BYTE, lzd_pkg::TYPE_LZ10, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h05, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h80, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'hF0, 1'b0));
		row_exp(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b1),
			rs(1'b0, 8'h00, 1'b1, 1'b0, lzd_pkg::ST_BADDIST, lzd_pkg::FMT_LZ10));
		// LZ11 extended size truncated by the last byte.
		row(mk(lzd_pkg::OP_BYTE, lzd_pkg::TYPE_LZ11, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row_exp(mk(lzd_pkg::OP_BYTE, 8'hFF, 1'b1),
			rs(1'b0, 8'h00, 1'b1, 1'b0, lzd_pkg::ST_TRUNC, lzd_pkg::FMT_LZ11));
		// LZ11 with a long copy: literal, then a copy pending, busy, continue.
		row(mk(lzd_pkg::OP_BYTE, lzd_pkg::TYPE_LZ11, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'hFF, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'hFF, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h7F, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h40, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'hAA, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h10, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b0));
		row(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b1));
		row_exp(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b1),
			rs(1'b0, 8'h00, 1'b1, 1'b0, lzd_pkg::ST_BUSY, lzd_pkg::FMT_LZ11));
		for (int i = 0; i < 5; i++)
			row(mk(lzd_pkg::OP_CONT, 8'h00, 1'b0));

		foreach (rows[i]) begin
			send_item(rows[i].stim);
			if (rows[i].has_exp && (pending_rsps.size() == 0 ||
				pending_rsps[pending_rsps.size()-1] !== rows[i].exp)) begin
				errors++;
				$error("directed row %0d: expected %p", i, rows[i].exp);
			end
		end
		// A stream cut off after two header bytes, which are passed back.
		send_item(mk(lzd_pkg::OP_BYTE, 8'h10, 1'b0));
		send_item(mk(lzd_pkg::OP_BYTE, 8'h00, 1'b1));

		// Random part in idling phases: streams, noise and broken streams.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 59; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 59; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			while (sent_items < 30 + (p + 1) * 90) begin
				phase_sel = $urandom_range(0, 9);
				stim_q.delete();
				if (phase_sel < 7) begin
					add_stream(phase_sel < 3 ? lzd_pkg::FMT_LZ10 :
						(phase_sel < 6 ? lzd_pkg::FMT_LZ11 : lzd_pkg::FMT_NONE));
				end else begin
					add_stream(2'($urandom_range(1, 2)));
					while (stim_q.size() > 1 && $urandom_range(0, 3) != 0)
						void'(stim_q.pop_back());
					stim_q[stim_q.size()-1].in_last = 1'b1;
					stim_q.push_back(mk(1'($urandom), 8'($urandom), 1'($urandom)));
					stim_q.push_back(mk(lzd_pkg::OP_BYTE, 8'($urandom), 1'b1));
				end
				foreach (stim_q[i])
					send_item(stim_q[i]);
			end
		end
		req_valid <= 1'b0;
		drain_wait();
		if (errors == 0) begin
			$display("tb_lz10_lz11_stream_decompressor passed");
		end else begin
			$display("tb_lz10_lz11_stream_decompressor failed");
		end
		$finish;
	end

endmodule
